// ----- design/assert_macros.svh -----
// Assertion macros for the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ----- design/swrl_pkg.sv -----
// Shared types and constants of the sliding-window rate limiter.
package swrl_pkg;

    localparam int TIME_W    = 32;
    localparam int USER_ID_W = 8;
    localparam int CNT_W     = 7;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;
    localparam int VERDICT_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_USER_LIMIT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SERVICE_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 2'd2;

    localparam logic [CNT_W-1:0]  USER_LIMIT_RST    = 7'd4;
    localparam logic [CNT_W-1:0]  SERVICE_LIMIT_RST = 7'd16;
    localparam logic [TIME_W-1:0] WINDOW_RST        = 32'd1000;

    localparam logic [VERDICT_W-1:0] VERDICT_ACCEPT  = 2'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_USER    = 2'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_SERVICE = 2'd2;

    // Controller to datapath commands.
    typedef struct packed {
        logic clr;         // clear one count entry
        logic latch;       // capture request
        logic head_rd;     // read oldest log entry
        logic cnt_rd_log;  // read count of the logged user
        logic pop;         // retire oldest entry
        logic cnt_rd_req;  // read count of the requesting user
        logic judge;       // decide and commit
    } cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic clr_last;
        logic occ_zero;
        logic expired;
    } stat_t;

endpackage

// ----- design/swrl_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module swrl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/swrl_datapath.sv -----
// Datapath: config registers, log and count memories, pointers, verdict.
module swrl_datapath #(
    parameter int LOG_DEPTH = 64,
    parameter int NUM_USERS = 256
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [swrl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [swrl_pkg::CFG_W-1:0]       cfg_wdata,
    input  logic [swrl_pkg::TIME_W-1:0]      timestamp,
    input  logic [swrl_pkg::USER_ID_W-1:0]   user_id,
    input  swrl_pkg::cmd_t                   cmd,
    output swrl_pkg::stat_t                  stat,
    output logic [swrl_pkg::VERDICT_W-1:0]   verdict
);

    localparam int TW = swrl_pkg::TIME_W;
    localparam int CW = swrl_pkg::CNT_W;
    localparam int UW = $clog2(NUM_USERS);
    localparam int LW = $clog2(LOG_DEPTH);
    localparam int OW = $clog2(LOG_DEPTH + 1);
    localparam int SW = (OW > CW) ? OW : CW;
    localparam int ID_N = 2 ** swrl_pkg::USER_ID_W;

    logic [CW-1:0] ulim_reg, slim_reg;
    logic [TW-1:0] win_reg;
    logic [LW-1:0] head_reg, tail_reg;
    logic [OW-1:0] occ_reg;
    logic [UW-1:0] clr_reg;
    logic [TW-1:0] now_reg;
    logic [UW-1:0] user_reg;
    logic [swrl_pkg::VERDICT_W-1:0] verdict_reg, verdict_next;

    // user number folded onto the count table
    logic [UW-1:0] umod [ID_N];
    for (genvar i = 0; i < ID_N; i++)
    begin : g_umod
        assign umod[i] = UW'(i % NUM_USERS);
    end

    logic [TW+UW-1:0] log_rdata;
    logic [TW-1:0]    log_time;
    logic [UW-1:0]    log_user;
    logic             log_we;
    logic [CW-1:0]    cnt_rdata, cnt_wdata;
    logic [UW-1:0]    cnt_waddr, cnt_raddr;
    logic             cnt_we;
    logic [TW:0]      deadline;
    logic             user_full, svc_full, accept;

    assign log_time = log_rdata[TW+UW-1:UW];
    assign log_user = log_rdata[UW-1:0];
    assign deadline = {1'b0, log_time} + {1'b0, win_reg};

    assign user_full = cnt_rdata >= ulim_reg;
    assign svc_full  = (SW'(occ_reg) >= SW'(slim_reg)) || (occ_reg >= OW'(LOG_DEPTH));
    assign accept    = !user_full && !svc_full;
    assign log_we    = cmd.judge && accept;

    always_comb
    begin
        if (user_full)
        begin
            verdict_next = swrl_pkg::VERDICT_USER;
        end
        else if (svc_full)
        begin
            verdict_next = swrl_pkg::VERDICT_SERVICE;
        end
        else
        begin
            verdict_next = swrl_pkg::VERDICT_ACCEPT;
        end
    end

    always_comb
    begin
        cnt_we    = 1'b0;
        cnt_waddr = user_reg;
        cnt_wdata = cnt_rdata + CW'(1);
        if (cmd.clr)
        begin
            cnt_we    = 1'b1;
            cnt_waddr = clr_reg;
            cnt_wdata = '0;
        end
        else if (cmd.pop)
        begin
            cnt_we    = 1'b1;
            cnt_waddr = log_user;
            cnt_wdata = (cnt_rdata != '0) ? cnt_rdata - CW'(1) : '0;
        end
        else if (log_we)
        begin
            cnt_we = 1'b1;
        end
    end

    assign cnt_raddr = cmd.cnt_rd_log ? log_user : user_reg;

    swrl_ram #(
        .WIDTH (TW + UW),
        .DEPTH (LOG_DEPTH)
    ) u_log_ram (
        .clk   (clk),
        .we    (log_we),
        .waddr (tail_reg),
        .wdata ({now_reg, user_reg}),
        .re    (cmd.head_rd),
        .raddr (head_reg),
        .rdata (log_rdata)
    );

    swrl_ram #(
        .WIDTH (CW),
        .DEPTH (NUM_USERS)
    ) u_cnt_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .re    (cmd.cnt_rd_log || cmd.cnt_rd_req),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ulim_reg <= swrl_pkg::USER_LIMIT_RST;
            slim_reg <= swrl_pkg::SERVICE_LIMIT_RST;
            win_reg  <= swrl_pkg::WINDOW_RST;
            head_reg <= '0;
            tail_reg <= '0;
            occ_reg  <= '0;
            clr_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    swrl_pkg::CFG_USER_LIMIT:    ulim_reg <= cfg_wdata[CW-1:0];
                    swrl_pkg::CFG_SERVICE_LIMIT: slim_reg <= cfg_wdata[CW-1:0];
                    swrl_pkg::CFG_WINDOW_LENGTH: win_reg  <= cfg_wdata[TW-1:0];
                    default: ;
                endcase
            end
            if (cmd.clr)
            begin
                clr_reg <= clr_reg + UW'(1);
            end
            if (cmd.pop)
            begin
                head_reg <= (head_reg == LW'(LOG_DEPTH - 1)) ? '0 : head_reg + LW'(1);
                occ_reg  <= occ_reg - OW'(1);
            end
            else if (log_we)
            begin
                tail_reg <= (tail_reg == LW'(LOG_DEPTH - 1)) ? '0 : tail_reg + LW'(1);
                occ_reg  <= occ_reg + OW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            now_reg  <= timestamp;
            user_reg <= umod[user_id];
        end
        if (cmd.judge)
        begin
            verdict_reg <= verdict_next;
        end
    end

    assign stat.clr_last = clr_reg == UW'(NUM_USERS - 1);
    assign stat.occ_zero = occ_reg == '0;
    assign stat.expired  = deadline < {1'b0, now_reg};
    assign verdict       = verdict_reg;

endmodule

// ----- design/swrl_ctrl.sv -----
// Controller: sequences clearing, expiry walk and judgement.
module swrl_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  swrl_pkg::stat_t stat,
    output swrl_pkg::cmd_t  cmd,
    output logic            busy,
    output logic            done
);

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_HEAD,
        S_DEAD,
        S_DEC,
        S_UREAD,
        S_JUDGE
    } state_t;

    state_t state_reg, state_next;
    logic   done_reg, done_next;

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        cmd        = '0;
        case (state_reg)
            S_CLR:
            begin
                cmd.clr = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_HEAD;
                end
            end
            S_HEAD:
            begin
                if (stat.occ_zero)
                begin
                    state_next = S_UREAD;
                end
                else
                begin
                    cmd.head_rd = 1'b1;
                    state_next  = S_DEAD;
                end
            end
            S_DEAD:
            begin
                if (stat.expired)
                begin
                    cmd.cnt_rd_log = 1'b1;
                    state_next     = S_DEC;
                end
                else
                begin
                    state_next = S_UREAD;
                end
            end
            S_DEC:
            begin
                cmd.pop    = 1'b1;
                state_next = S_HEAD;
            end
            S_UREAD:
            begin
                cmd.cnt_rd_req = 1'b1;
                state_next     = S_JUDGE;
            end
            S_JUDGE:
            begin
                cmd.judge  = 1'b1;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = state_reg != S_IDLE;
    assign done = done_reg;

endmodule

// ----- design/sliding_window_rate_limiter.sv -----
// Top level of the sliding-window rate limiter.
//
// channel   ports                                 transfer when
// -------   ------------------------------------  -------------------------------
// request   start, busy, timestamp, user_id       start && !busy at clk rise
// verdict   done, verdict                         done high (one cycle, no stall)
// config    cfg_we, cfg_index, cfg_wdata          cfg_we high at clk rise
//
// From request transfer to verdict transfer the controller reads the oldest log
// entry unless the log is empty, then reads the requester's count and judges; each
// expired entry is retired first by a log read, a deadline compare with count read
// and a count write-back through the count RAM. After reset busy stays high while
// the count RAM is swept to zero; config writes are taken during the sweep.
// The verdict receiver cannot stall; done pulses for exactly one cycle.
`include "assert_macros.svh"

module sliding_window_rate_limiter #(
    parameter int LOG_DEPTH = 64,
    parameter int NUM_USERS = 256
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // config write port
    input  logic                             cfg_we,
    input  logic [swrl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [swrl_pkg::CFG_W-1:0]       cfg_wdata,
    // request
    input  logic                             start,
    output logic                             busy,
    input  logic [swrl_pkg::TIME_W-1:0]      timestamp,
    input  logic [swrl_pkg::USER_ID_W-1:0]   user_id,
    // result
    output logic                             done,
    output logic [swrl_pkg::VERDICT_W-1:0]   verdict
);

    // commands down to the datapath, status back up
    swrl_pkg::cmd_t  cmd;
    swrl_pkg::stat_t stat;

    // Controller: owns the busy flag and the one-cycle done strobe.
    swrl_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // Datapath: circular log RAM (time, user), per-user count RAM,
    // head/tail/occupancy pointers and the config registers.
    swrl_datapath #(
        .LOG_DEPTH (LOG_DEPTH),
        .NUM_USERS (NUM_USERS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .timestamp (timestamp),
        .user_id   (user_id),
        .cmd       (cmd),
        .stat      (stat),
        .verdict   (verdict)
    );

    // A request transfer always makes the block busy next cycle.
    `ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy)
    // The verdict strobe lands back in idle and never repeats.
    `ASSERT_IMPL(a_done_idle, clk, rst_n, done, !busy)
    `ASSERT_NEXT(a_done_single, clk, rst_n, done, !done)
    // Pops and commits never happen in the same cycle.
    `ASSERT_IMPL(a_cmd_excl, clk, rst_n, cmd.pop, !cmd.judge && !cmd.clr)

endmodule
